### sv/rtch_pkg.sv
// Shared types and helpers for the ray/triangle closest-hit core.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package rtch_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_DIR_X      = 3'd3,
    REG_DIR_Y      = 3'd4,
    REG_DIR_Z      = 3'd5,
    REG_DET_LIMIT  = 3'd6,
    REG_MIN_DIST   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic [15:0]        tri_id;
    logic               final_tri;
  } tri_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        hit_t;
    logic [16:0]        hit_u;
    logic [16:0]        hit_v;
    logic [15:0]        hit_tri;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } res_t;

  // Ray registers as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
    logic signed [31:0] direction_z;
    logic [30:0]        det_zero_limit;
    logic [30:0]        min_distance;
  } cfg_t;

  // One classified triangle: its edges and the origin offset.
  typedef struct packed {
    logic signed [31:0] e1_x;
    logic signed [31:0] e1_y;
    logic signed [31:0] e1_z;
    logic signed [31:0] e2_x;
    logic signed [31:0] e2_y;
    logic signed [31:0] e2_z;
    logic signed [31:0] tv_x;
    logic signed [31:0] tv_y;
    logic signed [31:0] tv_z;
    logic [15:0]        tri_id;
    logic               final_tri;
  } item_t;

  localparam int unsigned AccW = 66;

  // Clamp a wide signed value into the 32-bit signed range.
  function automatic logic signed [31:0] sat_s32(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(64'sd2147483647);
    lo = -AccW'(64'sd2147483648);
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  // Saturating difference of two 32-bit signed values.
  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return sat_s32({{(AccW-33){d[32]}}, d});
  endfunction

endpackage
`default_nettype wire

### sv/rtch_front.sv
// Front end: takes triangles, forms saturated edges and origin offset.
// Depends on rtch_pkg; feeds the queue in front of the back end.
`default_nettype none
module rtch_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire rtch_pkg::tri_t tri_i,
  input  wire rtch_pkg::cfg_t cfg_i,
  output logic                item_valid_o,
  output rtch_pkg::item_t     item_o,
  input  wire logic           item_ready_i
);
  import rtch_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  assign full         = valid_q & ~item_ready_i;
  assign accept       = push & ~full;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = accept | (valid_q & ~item_ready_i);
    item_d  = item_q;
    if (accept) begin
      item_d.e1_x      = sub_sat(tri_i.b_x, tri_i.a_x);
      item_d.e1_y      = sub_sat(tri_i.b_y, tri_i.a_y);
      item_d.e1_z      = sub_sat(tri_i.b_z, tri_i.a_z);
      item_d.e2_x      = sub_sat(tri_i.c_x, tri_i.a_x);
      item_d.e2_y      = sub_sat(tri_i.c_y, tri_i.a_y);
      item_d.e2_z      = sub_sat(tri_i.c_z, tri_i.a_z);
      item_d.tv_x      = sub_sat(cfg_i.origin_x, tri_i.a_x);
      item_d.tv_y      = sub_sat(cfg_i.origin_y, tri_i.a_y);
      item_d.tv_z      = sub_sat(cfg_i.origin_z, tri_i.a_z);
      item_d.tri_id    = tri_i.tri_id;
      item_d.final_tri = tri_i.final_tri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule
`default_nettype wire

### sv/rtch_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on rtch_pkg for the item type.
`default_nettype none
module rtch_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_valid_i,
  input  wire rtch_pkg::item_t wr_item_i,
  output logic                 wr_ready_o,
  output logic                 rd_valid_o,
  output rtch_pkg::item_t      rd_item_o,
  input  wire logic            rd_pop_i
);
  import rtch_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i & wr_ready_o;
  assign do_rd      = rd_pop_i & rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule
`default_nettype wire

### sv/rtch_div.sv
// Bit-serial signed fixed-point divider: sat32((num << FRAC_BITS) / den).
// Depends on rtch_pkg only through the import convention; one bit a cycle.
`default_nettype none
module rtch_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);
  import rtch_pkg::*;

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [32:0]   rem_q;
  logic [NW-1:0] dvd_q;
  logic [31:0]   den_q;
  logic          neg_q, busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic signed [31:0] quot_q;

  logic [32:0]   rem_sh;
  logic          fits;
  logic [31:0]   num_mag, den_mag;
  logic [NW-1:0] pos_max, neg_max;

  assign num_mag = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign den_mag = den_i[31] ? (~den_i + 32'd1) : den_i;
  assign rem_sh  = {rem_q[31:0], dvd_q[NW-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign pos_max = NW'(64'h7fffffff);
  assign neg_max = NW'(64'h80000000);
  assign done_o  = done_q;
  assign quot_o  = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      den_q  <= '0;
      neg_q  <= 1'b0;
      quot_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(NW));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvd_q  <= {num_mag, {FRAC_BITS{1'b0}}};
        den_q  <= den_mag;
        neg_q  <= num_i[31] ^ den_i[31];
      end else if (busy_q) begin
        if (cnt_q == CW'(NW)) begin
          busy_q <= 1'b0;
          if (!neg_q) begin
            quot_q <= (dvd_q > pos_max) ? 32'sh7fffffff : dvd_q[31:0];
          end else begin
            quot_q <= (dvd_q > neg_max) ? 32'sh80000000 : (~dvd_q[31:0] + 32'd1);
          end
        end else begin
          cnt_q <= cnt_q + CW'(1);
          rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
          dvd_q <= {dvd_q[NW-2:0], fits};
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/rtch_back.sv
// Back end: sequenced intersection test on one shared multiplier and divider,
// nearest-hit keeping and the one-entry result register. Depends on rtch_pkg.
`default_nettype none
module rtch_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rtch_pkg::cfg_t  cfg_i,
  input  wire logic            item_valid_i,
  input  wire rtch_pkg::item_t item_i,
  output logic                 item_pop_o,
  output logic                 empty,
  input  wire logic            pop,
  output rtch_pkg::res_t       res_o
);
  import rtch_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_CKDET, S_DIV, S_FIN, S_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_DIR0, OP_DIR1, OP_DIR2, OP_E1_0, OP_E1_1, OP_E1_2, OP_E2_0, OP_E2_1, OP_E2_2,
    OP_TV0, OP_TV1, OP_TV2, OP_P0, OP_P1, OP_P2, OP_Q0, OP_Q1, OP_Q2, OP_BT
  } opnd_e;

  typedef enum logic [3:0] {
    D_NONE, D_P0, D_P1, D_P2, D_Q0, D_Q1, D_Q2, D_DET, D_NUM, D_PT0, D_PT1, D_PT2
  } dest_e;

  typedef enum logic [1:0] { DV_U, DV_V, DV_T } div_sel_e;

  typedef struct packed {
    opnd_e a;
    opnd_e b;
    logic  neg;
    logic  first;
    dest_e dest;
  } step_t;

  localparam logic [4:0] StepDetEnd = 5'd8;
  localparam logic [4:0] StepUEnd   = 5'd11;
  localparam logic [4:0] StepQStart = 5'd12;
  localparam logic [4:0] StepVEnd   = 5'd20;
  localparam logic [4:0] StepTStart = 5'd21;
  localparam logic [4:0] StepTEnd   = 5'd23;
  localparam logic [4:0] StepPtStart = 5'd24;
  localparam logic [4:0] StepPtEnd  = 5'd26;
  localparam logic signed [33:0] One = 34'sd1 <<< FRAC_BITS;

  // The whole test as a list of multiply-accumulate steps.
  function automatic step_t step_info(input logic [4:0] s);
    step_t r;
    r = '{a: OP_DIR0, b: OP_DIR0, neg: 1'b0, first: 1'b0, dest: D_NONE};
    case (s)
      5'd0:  r = '{OP_DIR1, OP_E2_2, 1'b0, 1'b1, D_NONE};
      5'd1:  r = '{OP_DIR2, OP_E2_1, 1'b1, 1'b0, D_P0};
      5'd2:  r = '{OP_DIR2, OP_E2_0, 1'b0, 1'b1, D_NONE};
      5'd3:  r = '{OP_DIR0, OP_E2_2, 1'b1, 1'b0, D_P1};
      5'd4:  r = '{OP_DIR0, OP_E2_1, 1'b0, 1'b1, D_NONE};
      5'd5:  r = '{OP_DIR1, OP_E2_0, 1'b1, 1'b0, D_P2};
      5'd6:  r = '{OP_E1_0, OP_P0, 1'b0, 1'b1, D_NONE};
      5'd7:  r = '{OP_E1_1, OP_P1, 1'b0, 1'b0, D_NONE};
      5'd8:  r = '{OP_E1_2, OP_P2, 1'b0, 1'b0, D_DET};
      5'd9:  r = '{OP_TV0, OP_P0, 1'b0, 1'b1, D_NONE};
      5'd10: r = '{OP_TV1, OP_P1, 1'b0, 1'b0, D_NONE};
      5'd11: r = '{OP_TV2, OP_P2, 1'b0, 1'b0, D_NUM};
      5'd12: r = '{OP_TV1, OP_E1_2, 1'b0, 1'b1, D_NONE};
      5'd13: r = '{OP_TV2, OP_E1_1, 1'b1, 1'b0, D_Q0};
      5'd14: r = '{OP_TV2, OP_E1_0, 1'b0, 1'b1, D_NONE};
      5'd15: r = '{OP_TV0, OP_E1_2, 1'b1, 1'b0, D_Q1};
      5'd16: r = '{OP_TV0, OP_E1_1, 1'b0, 1'b1, D_NONE};
      5'd17: r = '{OP_TV1, OP_E1_0, 1'b1, 1'b0, D_Q2};
      5'd18: r = '{OP_DIR0, OP_Q0, 1'b0, 1'b1, D_NONE};
      5'd19: r = '{OP_DIR1, OP_Q1, 1'b0, 1'b0, D_NONE};
      5'd20: r = '{OP_DIR2, OP_Q2, 1'b0, 1'b0, D_NUM};
      5'd21: r = '{OP_E2_0, OP_Q0, 1'b0, 1'b1, D_NONE};
      5'd22: r = '{OP_E2_1, OP_Q1, 1'b0, 1'b0, D_NONE};
      5'd23: r = '{OP_E2_2, OP_Q2, 1'b0, 1'b0, D_NUM};
      5'd24: r = '{OP_BT, OP_DIR0, 1'b0, 1'b1, D_PT0};
      5'd25: r = '{OP_BT, OP_DIR1, 1'b0, 1'b1, D_PT1};
      5'd26: r = '{OP_BT, OP_DIR2, 1'b0, 1'b1, D_PT2};
      default: r = '{OP_DIR0, OP_DIR0, 1'b0, 1'b1, D_NONE};
    endcase
    return r;
  endfunction

  state_e   state_q;
  logic [4:0] step_q;
  item_t    it_q;
  logic signed [31:0] p_q [3];
  logic signed [31:0] q_q [3];
  logic signed [31:0] pt_q [3];
  logic signed [31:0] det_q, num_q, u_q, v_q;
  logic signed [63:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  div_sel_e div_sel_q;
  logic     div_start_q;
  logic     best_valid_q;
  logic [30:0] best_t_q;
  logic [16:0] best_u_q, best_v_q;
  logic [15:0] best_index_q;
  logic     res_valid_q;
  res_t     res_q;

  step_t    st;
  logic signed [31:0] opa, opb;
  logic signed [AccW-1:0] term, base, acc_n;
  logic signed [31:0] acc_sat;
  logic     div_done;
  logic signed [31:0] div_q;
  logic [31:0] adet;
  logic signed [33:0] uv_sum;
  logic     t_ok, take;
  logic     res_load;
  logic     div_end;

  function automatic logic signed [31:0] opnd(input opnd_e s, input item_t it,
                                              input cfg_t c,
                                              input logic signed [31:0] p [3],
                                              input logic signed [31:0] q [3],
                                              input logic [30:0] bt);
    logic signed [31:0] r;
    case (s)
      OP_DIR0: r = c.direction_x;
      OP_DIR1: r = c.direction_y;
      OP_DIR2: r = c.direction_z;
      OP_E1_0: r = it.e1_x;
      OP_E1_1: r = it.e1_y;
      OP_E1_2: r = it.e1_z;
      OP_E2_0: r = it.e2_x;
      OP_E2_1: r = it.e2_y;
      OP_E2_2: r = it.e2_z;
      OP_TV0:  r = it.tv_x;
      OP_TV1:  r = it.tv_y;
      OP_TV2:  r = it.tv_z;
      OP_P0:   r = p[0];
      OP_P1:   r = p[1];
      OP_P2:   r = p[2];
      OP_Q0:   r = q[0];
      OP_Q1:   r = q[1];
      OP_Q2:   r = q[2];
      OP_BT:   r = {1'b0, bt};
      default: r = '0;
    endcase
    return r;
  endfunction

  assign st   = step_info(step_q);
  assign opa  = opnd(st.a, it_q, cfg_i, p_q, q_q, best_t_q);
  assign opb  = opnd(st.b, it_q, cfg_i, p_q, q_q, best_t_q);
  // Arithmetic shift of the exact product rounds toward minus infinity.
  assign term = $signed({{(AccW-64){prod_q[63]}}, prod_q}) >>> FRAC_BITS;

  always_comb begin
    base = acc_q;
    if (st.first) begin
      case (st.dest)
        D_PT0:   base = {{(AccW-32){cfg_i.origin_x[31]}}, cfg_i.origin_x};
        D_PT1:   base = {{(AccW-32){cfg_i.origin_y[31]}}, cfg_i.origin_y};
        D_PT2:   base = {{(AccW-32){cfg_i.origin_z[31]}}, cfg_i.origin_z};
        default: base = '0;
      endcase
    end
    acc_n = st.neg ? (base - term) : (base + term);
  end

  assign acc_sat  = sat_s32(acc_n);
  assign adet     = det_q[31] ? (~det_q + 32'd1) : det_q;
  assign uv_sum   = {{2{u_q[31]}}, u_q} + {{2{div_q[31]}}, div_q};
  assign t_ok     = !div_q[31] && ({1'b0, div_q[30:0]} >= {1'b0, cfg_i.min_distance});
  assign take     = t_ok && (!best_valid_q || (div_q[30:0] < best_t_q));
  assign res_load = (state_q == S_EMIT) && (!res_valid_q || pop);
  assign div_end  = (step_q == StepUEnd) || (step_q == StepVEnd) || (step_q == StepTEnd);
  assign item_pop_o = (state_q == S_IDLE) && item_valid_i;
  assign empty    = ~res_valid_q;
  assign res_o    = res_q;

  rtch_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (num_q),
    .den_i   (det_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      it_q         <= '0;
      p_q          <= '{default: '0};
      q_q          <= '{default: '0};
      pt_q         <= '{default: '0};
      det_q        <= '0;
      num_q        <= '0;
      u_q          <= '0;
      v_q          <= '0;
      prod_q       <= '0;
      acc_q        <= '0;
      div_sel_q    <= DV_U;
      div_start_q  <= 1'b0;
      best_valid_q <= 1'b0;
      best_t_q     <= '0;
      best_u_q     <= '0;
      best_v_q     <= '0;
      best_index_q <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      div_start_q <= (state_q == S_ACC) && div_end;
      if (pop && res_valid_q && !res_load) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            it_q    <= item_i;
            step_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= opa * opb;
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= acc_n;
          step_q  <= step_q + 5'd1;
          case (st.dest)
            D_P0:  p_q[0] <= acc_sat;
            D_P1:  p_q[1] <= acc_sat;
            D_P2:  p_q[2] <= acc_sat;
            D_Q0:  q_q[0] <= acc_sat;
            D_Q1:  q_q[1] <= acc_sat;
            D_Q2:  q_q[2] <= acc_sat;
            D_DET: det_q  <= acc_sat;
            D_NUM: num_q  <= acc_sat;
            D_PT0: pt_q[0] <= acc_sat;
            D_PT1: pt_q[1] <= acc_sat;
            D_PT2: pt_q[2] <= acc_sat;
            default: ;
          endcase
          if (step_q == StepDetEnd) begin
            state_q <= S_CKDET;
          end else if (div_end) begin
            state_q     <= S_DIV;
            div_sel_q   <= (step_q == StepUEnd) ? DV_U :
                           (step_q == StepVEnd) ? DV_V : DV_T;
          end else if (step_q == StepPtEnd) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_CKDET: begin
          state_q <= (adet > {1'b0, cfg_i.det_zero_limit}) ? S_MUL : S_FIN;
        end
        S_DIV: begin
          if (div_done) begin
            case (div_sel_q)
              DV_U: begin
                u_q <= div_q;
                if (!div_q[31] && ({{2{div_q[31]}}, div_q} <= One)) begin
                  step_q  <= StepQStart;
                  state_q <= S_MUL;
                end else begin
                  state_q <= S_FIN;
                end
              end
              DV_V: begin
                v_q <= div_q;
                if (!div_q[31] && (uv_sum <= One)) begin
                  step_q  <= StepTStart;
                  state_q <= S_MUL;
                end else begin
                  state_q <= S_FIN;
                end
              end
              default: begin
                if (take) begin
                  best_valid_q <= 1'b1;
                  best_t_q     <= div_q[30:0];
                  best_u_q     <= u_q[16:0];
                  best_v_q     <= v_q[16:0];
                  best_index_q <= it_q.tri_id;
                end
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (!it_q.final_tri) begin
            state_q <= S_IDLE;
          end else if (best_valid_q) begin
            step_q  <= StepPtStart;
            state_q <= S_MUL;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_load) begin
            res_valid_q <= 1'b1;
            if (best_valid_q) begin
              res_q <= '{hit: 1'b1, hit_t: best_t_q, hit_u: best_u_q, hit_v: best_v_q,
                         hit_tri: best_index_q, point_x: pt_q[0], point_y: pt_q[1],
                         point_z: pt_q[2]};
            end else begin
              res_q <= '0;
            end
            best_valid_q <= 1'b0;
            best_t_q     <= '0;
            best_u_q     <= '0;
            best_v_q     <= '0;
            best_index_q <= '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> !best_valid_q && res_valid_q)
    else $error("kept hit not cleared after the result was written");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |=> state_q == S_MUL && step_q == '0)
    else $error("item taken without starting the step program");

endmodule
`default_nettype wire

### sv/ray_triangle_closest_hit_core.sv
// Ray/triangle closest-hit core. The ray (origin, direction, determinant limit
// and minimum distance) must be set through the write port only while the core
// is idle; the core itself does not enforce this. Triangles are then pushed one
// at a time and the last one of a ray, marked by final_tri, produces exactly one
// result: the nearest accepted hit (ties keep the earlier triangle) with its
// distance, barycentrics, index and hit point, or all zeros when nothing was
// hit. All values are signed fixed point with FRAC_BITS fraction bits (Q16.16
// by default) and saturate. A small front stage forms the edges and accepts the
// next triangle while the back end is still working; a two-entry queue lies
// between them. The back end runs each test on one shared 32x32 multiplier and
// one bit-serial divider that holds the back end until each quotient is done. A
// triangle rejected by the determinant skips the divisions, and the last
// triangle of a hit ray goes on to compute the hit point.

`default_nettype none
module ray_triangle_closest_hit_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire rtch_pkg::tri_t                  tri_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output rtch_pkg::res_t                       res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rtch_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [rtch_pkg::CfgDataW-1:0]   cfg_data_i
);
  import rtch_pkg::*;

  // Ray registers; the limits keep their low 31 bits.
  cfg_t  cfg_q;
  logic  f_valid, q_ready, q_valid, q_pop;
  item_t f_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{origin_x: '0, origin_y: '0, origin_z: '0,
                 direction_x: '0, direction_y: '0, direction_z: 32'sd65536,
                 det_zero_limit: 31'd1, min_distance: 31'd1};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ORIGIN_X:  cfg_q.origin_x       <= cfg_data_i;
        REG_ORIGIN_Y:  cfg_q.origin_y       <= cfg_data_i;
        REG_ORIGIN_Z:  cfg_q.origin_z       <= cfg_data_i;
        REG_DIR_X:     cfg_q.direction_x    <= cfg_data_i;
        REG_DIR_Y:     cfg_q.direction_y    <= cfg_data_i;
        REG_DIR_Z:     cfg_q.direction_z    <= cfg_data_i;
        REG_DET_LIMIT: cfg_q.det_zero_limit <= cfg_data_i[30:0];
        REG_MIN_DIST:  cfg_q.min_distance   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  rtch_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .tri_i        (tri_i),
    .cfg_i        (cfg_q),
    .item_valid_o (f_valid),
    .item_o       (f_item),
    .item_ready_i (q_ready)
  );

  rtch_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_item_i  (f_item),
    .wr_ready_o (q_ready),
    .rd_valid_o (q_valid),
    .rd_item_o  (q_item),
    .rd_pop_i   (q_pop)
  );

  rtch_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res_o)
  );

endmodule
`default_nettype wire
